/* rtl/core/fq_pkg.sv */
// ----------------------------------------------------------------------------
// fq_pkg
// Shared types and constants for the handle queue: depth, widths, operation
// and status codes, cell control bundle and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package fq_pkg;

    // Queue geometry
    localparam int DEPTH       = 64;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int HANDLE_W    = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_PEEK    = 2'd3
    } fq_op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4
    } fq_status_t;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fq_state_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic capture;  // latch the compare result for a new transaction
        logic remove;   // close the gap behind the first marked cell
        logic append;   // write the handle into the tail cell
    } fq_cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/fq_cell.sv */
// ----------------------------------------------------------------------------
// fq_cell
// One queue slot: holds a handle, compares it against an incoming handle,
// passes a removal mark down the chain and takes its neighbor's handle when
// the gap closes.
// ----------------------------------------------------------------------------
`default_nettype none

module fq_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fq_pkg::fq_cell_ctrl_t         ctrl,
    input  wire logic                          occupied,
    input  wire logic                          tail,
    input  wire logic [fq_pkg::HANDLE_W-1:0]   cmp_handle,
    input  wire logic [fq_pkg::HANDLE_W-1:0]   wr_handle,
    input  wire logic [fq_pkg::HANDLE_W-1:0]   next_data,
    input  wire logic                          kill_in,
    output logic      [fq_pkg::HANDLE_W-1:0]   data,
    output logic                               kill_out
);
    import fq_pkg::*;

    logic [HANDLE_W-1:0] data_reg;
    logic [HANDLE_W-1:0] data_next;
    logic                match_reg;
    logic                match_next;

    // Compare only live entries
    assign match_next = occupied && (data_reg == cmp_handle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            match_reg <= match_next;
        end
    end

    // Mark this cell and everything behind the first match
    assign kill_out = kill_in || match_reg;

    // Shift forward on removal, load on append, else hold
    always_comb
    begin
        priority if (ctrl.remove && kill_out)
        begin
            data_next = next_data;
        end
        else if (ctrl.append && tail)
        begin
            data_next = wr_handle;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/core/fifo_queue_with_delete_top.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_top
// Bounded FIFO of handles with enqueue, dequeue, delete-by-value and peek,
// built as a chain of slot cells that compare in parallel and shift together.
// ----------------------------------------------------------------------------
// Timing: a transaction's result is registered on execute, which is held off
// while an untaken result still holds the output.
// Flow: a new transaction is taken only after the last has executed; cell
// compares are registered at acceptance, match chain and shift on execute.
// Reset: asynchronous, clears the count, sequencer and output valid; slot
// contents are left unset and only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_delete_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fq_pkg::OP_W-1:0]       operation,
    input  wire logic [fq_pkg::HANDLE_W-1:0]   handle,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [fq_pkg::STATUS_W-1:0]   status,
    output logic      [fq_pkg::HANDLE_W-1:0]   handle_out,
    output logic      [fq_pkg::COUNT_OUT_W-1:0] count
);
    import fq_pkg::*;

    fq_state_t            state_reg;
    fq_state_t            state_next;
    logic                 accept;
    logic                 go;

    fq_op_t               op_reg;
    logic [HANDLE_W-1:0]  handle_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    fq_status_t           status_reg;
    fq_status_t           status_next;
    logic [HANDLE_W-1:0]  hout_reg;
    logic [HANDLE_W-1:0]  hout_next;
    logic [COUNT_OUT_W-1:0] cnt_out_reg;

    fq_cell_ctrl_t        cell_ctrl;
    logic                 remove;
    logic                 append;
    logic [DEPTH-1:0]     occ;
    logic [DEPTH-1:0]     tail;
    logic [HANDLE_W-1:0]  cell_data [DEPTH];
    logic [DEPTH:0]       kill;

    logic                 is_empty;
    logic                 is_full;
    logic                 is_zero;
    logic                 found;

    // Sequencer: take one transaction, execute once the output slot frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        go         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    go         = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // Hold the request for the execute cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= fq_op_t'(operation);
            handle_reg <= handle;
        end
    end

    // Occupancy and tail position per cell
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_pos
            assign occ[gi]  = (CNT_W'(gi) < count_reg);
            assign tail[gi] = (CNT_W'(gi) == count_reg);
        end
    endgenerate

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_zero  = (handle_reg == '0);

    // Dequeue marks the front cell; delete relies on the compare marks
    assign kill[0] = (op_reg == OP_DEQUEUE);
    assign found   = kill[DEPTH];

    // Decode the operation into status, result and cell commands
    always_comb
    begin
        status_next = ST_OK;
        hout_next   = '0;
        count_next  = count_reg;
        remove      = 1'b0;
        append      = 1'b0;
        unique case (op_reg)
            OP_ENQUEUE:
            begin
                if (is_zero)
                begin
                    status_next = ST_INVALID;
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    append     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEQUEUE:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    hout_next  = cell_data[0];
                    remove     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (is_empty)
                begin
                    status_next = ST_OK;
                end
                else if (is_zero)
                begin
                    status_next = ST_INVALID;
                end
                else if (found)
                begin
                    remove     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            OP_PEEK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    hout_next = cell_data[0];
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign cell_ctrl.capture = accept;
    assign cell_ctrl.remove  = go && remove;
    assign cell_ctrl.append  = go && append;

    // Chain of slot cells, front at index zero
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [HANDLE_W-1:0] nbr_data;
            if (gi == DEPTH - 1)
            begin : g_last
                assign nbr_data = '0;
            end
            else
            begin : g_mid
                assign nbr_data = cell_data[gi+1];
            end

            fq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .occupied   (occ[gi]),
                .tail       (tail[gi]),
                .cmp_handle (handle),
                .wr_handle  (handle_reg),
                .next_data  (nbr_data),
                .kill_in    (kill[gi]),
                .data       (cell_data[gi]),
                .kill_out   (kill[gi+1])
            );
        end
    endgenerate

    // Update the count on execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (go)
        begin
            count_reg <= count_next;
        end
    end

    // Output register: load on execute, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg  <= status_next;
            hout_reg    <= hout_next;
            cnt_out_reg <= COUNT_OUT_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_out = hout_reg;
    assign count      = cnt_out_reg;

    // Count stays within the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    // Count moves by at most one per transaction
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 ||
             count_reg == $past(count_reg) - 1'b1))
        else $error("queue count jumped by more than one");

    // A fresh result follows an execute cycle
    a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without an execute cycle");

    // An empty report carries no handle and a zero count
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_EMPTY) |->
            (hout_reg == '0 && count_reg == '0))
        else $error("empty result with nonzero handle or count");

endmodule

`default_nettype wire
